@@ rtl/core/mpgs_pkg.sv @@
package mpgs_pkg;

   localparam int DATA_WIDTH = 62;
   localparam int BIT_CNT_W  = $clog2(DATA_WIDTH);
   localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = DATA_WIDTH'(64'd1000000000007);

   typedef logic [DATA_WIDTH-1:0] data_type;

   typedef enum logic [1:0] {
      OP_POWER   = 2'd0,
      OP_SUM     = 2'd1,
      OP_SUM_SQ  = 2'd2,
      OP_UNUSED  = 2'd3
   } opcode_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      DP_NOP       = 4'd0,
      DP_LOAD      = 4'd1,   // latch operands, start k mod m
      DP_MUL_KK    = 4'd2,   // k = k*k
      DP_MUL_PS    = 4'd3,   // t = p*s
      DP_MUL_PP    = 4'd4,   // p = p*p
      DP_MUL_PK    = 4'd5,   // p = p*k
      DP_ADD_ST    = 4'd6,   // s = s+t
      DP_ADD_SP    = 4'd7,   // s = s+p
      DP_SHIFT_N   = 4'd8    // advance exponent bit
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      start;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;        // multiply or reduce unit running
      logic n_bit;       // current exponent msb
      logic last_bit;    // current bit is bit 0
      logic mod_ok;      // modulus >= 2
   } dp_status_type;

endpackage

@@ rtl/core/mpgs_datapath.sv @@
module mpgs_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  mpgs_pkg::data_type      csr_modulus,
   input  mpgs_pkg::data_type      base_value,
   input  mpgs_pkg::data_type      exponent,
   input  mpgs_pkg::dp_cmd_type    cmd,
   output mpgs_pkg::dp_status_type status,
   output mpgs_pkg::data_type      p_value,
   output mpgs_pkg::data_type      s_value
);
   import mpgs_pkg::*;

   // operand/result registers
   data_type m_ff, m_in;
   data_type k_ff, k_in;
   data_type p_ff, p_in;
   data_type s_ff, s_in;
   data_type t_ff, t_in;
   data_type n_ff, n_in;
   logic [BIT_CNT_W-1:0] bit_ff, bit_in;

   // shared serial unit: either shift-add multiply or restoring reduction
   logic                 run_ff, run_in;
   logic                 red_ff, red_in;   // 1: reduction of x mod m
   dp_op_type            dst_ff, dst_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   data_type             a_ff, a_in;
   data_type             b_ff, b_in;
   data_type             acc_ff, acc_in;

   logic [DATA_WIDTH:0]  dbl, dbl_r, addv, addv_r, sum2;
   data_type             x_sel, y_sel, step_acc;

   always_comb begin
      // one bit of multiply / reduction per cycle
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      if (red_ff) begin
         // acc = 2*acc + bit, reduce
         addv   = {acc_ff, b_ff[DATA_WIDTH-1]};
         addv_r = (addv >= {1'b0, m_ff}) ? addv - {1'b0, m_ff} : addv;
         step_acc = addv_r[DATA_WIDTH-1:0];
      end else begin
         addv   = dbl_r + {1'b0, a_ff};
         addv_r = (addv >= {1'b0, m_ff}) ? addv - {1'b0, m_ff} : addv;
         step_acc = b_ff[DATA_WIDTH-1] ? addv_r[DATA_WIDTH-1:0]
                                       : dbl_r[DATA_WIDTH-1:0];
      end
   end

   always_comb begin
      unique case (cmd.op)
         DP_MUL_KK: begin x_sel = k_ff; y_sel = k_ff; end
         DP_MUL_PS: begin x_sel = p_ff; y_sel = s_ff; end
         DP_MUL_PP: begin x_sel = p_ff; y_sel = p_ff; end
         DP_MUL_PK: begin x_sel = k_ff; y_sel = p_ff; end
         default:   begin x_sel = s_ff; y_sel = t_ff; end
      endcase
      sum2 = {1'b0, s_ff} + {1'b0, (cmd.op == DP_ADD_ST) ? t_ff : p_ff};
      if (sum2 >= {1'b0, m_ff}) sum2 = sum2 - {1'b0, m_ff};
   end

   always_comb begin
      m_in = m_ff; k_in = k_ff; p_in = p_ff; s_in = s_ff; t_in = t_ff;
      n_in = n_ff; bit_in = bit_ff;
      run_in = run_ff; red_in = red_ff; dst_in = dst_ff; cnt_in = cnt_ff;
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff;
      if (run_ff) begin
         acc_in = step_acc;
         b_in   = {b_ff[DATA_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in = 1'b0;
            unique case (dst_ff)
               DP_LOAD, DP_MUL_KK, DP_MUL_PK: begin
                  if (dst_ff == DP_MUL_PK) p_in = step_acc;
                  else k_in = step_acc;
               end
               DP_MUL_PS: t_in = step_acc;
               default:   p_in = step_acc;
            endcase
         end
      end else if (cmd.start) begin
         unique case (cmd.op)
            DP_LOAD: begin
               m_in = csr_modulus; n_in = exponent;
               bit_in = BIT_CNT_W'(DATA_WIDTH-1);
               p_in = DATA_WIDTH'(1); s_in = '0; t_in = '0;
               run_in = 1'b1; red_in = 1'b1; dst_in = DP_LOAD;
               cnt_in = BIT_CNT_W'(DATA_WIDTH-1);
               a_in = '0; b_in = base_value; acc_in = '0;
            end
            DP_MUL_KK, DP_MUL_PS, DP_MUL_PP, DP_MUL_PK: begin
               run_in = 1'b1; red_in = 1'b0; dst_in = cmd.op;
               cnt_in = BIT_CNT_W'(DATA_WIDTH-1);
               a_in = x_sel; b_in = y_sel; acc_in = '0;
            end
            DP_ADD_ST, DP_ADD_SP: s_in = sum2[DATA_WIDTH-1:0];
            DP_SHIFT_N: begin
               n_in = {n_ff[DATA_WIDTH-2:0], 1'b0};
               bit_in = bit_ff - 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      m_ff <= m_in; k_ff <= k_in; p_ff <= p_in; s_ff <= s_in; t_ff <= t_in;
      n_ff <= n_in; bit_ff <= bit_in; red_ff <= red_in; dst_ff <= dst_in;
      cnt_ff <= cnt_in; a_ff <= a_in; b_ff <= b_in; acc_ff <= acc_in;
   end

   assign status.busy     = run_ff;
   assign status.n_bit    = n_ff[DATA_WIDTH-1];
   assign status.last_bit = (bit_ff == '0);
   assign status.mod_ok   = (m_ff >= DATA_WIDTH'(2));
   assign p_value = p_ff;
   assign s_value = s_ff;

   a_no_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> !(cmd.start && cmd.op == DP_LOAD)) else $error("load while busy");
   a_acc_lt_m: assert property (@(posedge clock) disable iff (reset)
      run_ff && !red_ff |=> !run_ff || acc_ff < m_ff) else $error("acc not reduced");
   a_cnt_done: assert property (@(posedge clock) disable iff (reset)
      run_ff && cnt_ff == '0 |=> !run_ff) else $error("unit overran");
endmodule

@@ rtl/core/mpgs_control.sv @@
module mpgs_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mpgs_pkg::opcode_type    req_op,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_sel_s,
   output logic                    rsp_zero,
   output mpgs_pkg::dp_cmd_type    cmd,
   input  mpgs_pkg::dp_status_type status
);
   import mpgs_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_RED   = 11'b00000000010,
      ST_SQK   = 11'b00000000100,
      ST_MPS   = 11'b00000001000,
      ST_AST   = 11'b00000010000,
      ST_MPP   = 11'b00000100000,
      ST_MPK   = 11'b00001000000,
      ST_ASP   = 11'b00010000000,
      ST_NEXT  = 11'b00100000000,
      ST_WAIT  = 11'b01000000000,
      ST_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   opcode_type op_ff, op_in;
   logic sel_ff, sel_in, zero_ff, zero_in;
   logic is_sum;

   assign is_sum = (op_ff != OP_POWER);

   always_comb begin
      state_in = state_ff; op_in = op_ff; sel_in = sel_ff; zero_in = zero_ff;
      cmd.op = DP_NOP; cmd.start = 1'b0;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            op_in = req_op; cmd.op = DP_LOAD; cmd.start = 1'b1;
            state_in = ST_RED;
         end
         ST_RED: if (!status.busy) begin
            sel_in = is_sum;
            zero_in = !status.mod_ok || op_ff == OP_UNUSED;
            if (zero_in) state_in = ST_DONE;
            else if (op_ff == OP_SUM_SQ) begin
               cmd.op = DP_MUL_KK; cmd.start = 1'b1; state_in = ST_SQK;
            end else if (is_sum) begin
               cmd.op = DP_MUL_PS; cmd.start = 1'b1; state_in = ST_MPS;
            end else begin
               cmd.op = DP_MUL_PP; cmd.start = 1'b1; state_in = ST_MPP;
            end
         end
         ST_SQK: if (!status.busy) begin
            cmd.op = DP_MUL_PS; cmd.start = 1'b1; state_in = ST_MPS;
         end
         ST_MPS: if (!status.busy) begin
            cmd.op = DP_ADD_ST; cmd.start = 1'b1; state_in = ST_AST;
         end
         ST_AST: begin
            cmd.op = DP_MUL_PP; cmd.start = 1'b1; state_in = ST_MPP;
         end
         ST_MPP: if (!status.busy) begin
            if (status.n_bit) begin
               cmd.op = DP_MUL_PK; cmd.start = 1'b1; state_in = ST_MPK;
            end else state_in = ST_NEXT;
         end
         ST_MPK: if (!status.busy) begin
            if (is_sum) begin
               cmd.op = DP_ADD_SP; cmd.start = 1'b1;
            end
            state_in = ST_NEXT;
         end
         ST_ASP: state_in = ST_NEXT;
         ST_NEXT: begin
            if (status.last_bit) state_in = ST_DONE;
            else begin
               cmd.op = DP_SHIFT_N; cmd.start = 1'b1; state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (is_sum) begin
               cmd.op = DP_MUL_PS; cmd.start = 1'b1; state_in = ST_MPS;
            end else begin
               cmd.op = DP_MUL_PP; cmd.start = 1'b1; state_in = ST_MPP;
            end
         end
         ST_DONE: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in; sel_ff <= sel_in; zero_ff <= zero_in;
   end

   assign rsp_sel_s = sel_ff;
   assign rsp_zero  = zero_ff;

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready during response");
   a_rsp_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready) else $error("no return to idle");
endmodule

@@ rtl/core/modular_power_and_geometric_sum.sv @@
// Channel  | Ports                                  | Direction
// request  | req_valid/ready, opcode, base, exponent | in
// response | rsp_valid/ready, rsp_result           | out
// csr      | csr_write_enable, csr_write_data        | in
// One request at a time. Reducing k mod m comes first; each of the 62 exponent
// bits then costs one or two serial multiplies for a power, two or three for a
// sum, plus control states. All of them run on the single shared serial unit.
// Reset is synchronous and restores the modulus. The result is held until rsp_ready;
// no new request is taken meanwhile.
module modular_power_and_geometric_sum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  mpgs_pkg::data_type   req_base_value,
   input  mpgs_pkg::data_type   req_exponent,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mpgs_pkg::data_type   rsp_result,
   input  logic                 csr_write_enable,
   input  mpgs_pkg::data_type   csr_write_data
);
   import mpgs_pkg::*;

   data_type modulus_ff;
   dp_cmd_type cmd;
   dp_status_type status;
   data_type p_value, s_value;
   logic sel_s, zero;

   always_ff @(posedge clock) begin
      if (reset) modulus_ff <= MODULUS_RESET;
      else if (csr_write_enable) modulus_ff <= csr_write_data;
   end

   mpgs_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .req_op(opcode_type'(req_opcode)),
      .rsp_valid, .rsp_ready, .rsp_sel_s(sel_s), .rsp_zero(zero),
      .cmd, .status
   );

   mpgs_datapath u_dp (
      .clock, .reset, .csr_modulus(modulus_ff),
      .base_value(req_base_value), .exponent(req_exponent),
      .cmd, .status, .p_value, .s_value
   );

   assign rsp_result = zero ? '0 : (sel_s ? s_value : p_value);
endmodule
